[rtl/sorted_scan_list_dedup_core_assert.svh]
// Assertion macros for the scan list core.
`ifndef SORTED_SCAN_LIST_DEDUP_CORE_ASSERT_SVH
`define SORTED_SCAN_LIST_DEDUP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSLD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ssld_pkg.sv]
package ssld_pkg;

	localparam int SSLD_LIST_DEPTH = 16;
	localparam int SSLD_WORD_W     = 64;
	localparam int SSLD_ADDR_W     = 48;
	localparam int SSLD_RSSI_W     = 8;
	localparam int SSLD_PREFIX_W   = 40;
	localparam int SSLD_INDEX_W    = 4;
	localparam int SSLD_TOTAL_W    = 5;
	localparam int SSLD_CFG_IDX_W  = 1;

	localparam logic [SSLD_PREFIX_W-1:0] SSLD_REJECT_RESET = 40'h1e_ff06_0001;
	localparam logic [7:0]               SSLD_RESERVED     = 8'hff;

	// Register indexes of the configuration port
	typedef enum logic [SSLD_CFG_IDX_W-1:0] {
		REG_REJECT_PATTERN = 1'b0,
		REG_REJECT_ENABLE  = 1'b1
	} ssld_reg_t;

	// Command codes on the input item
	typedef enum logic {
		CMD_ADVERT    = 1'b0,
		CMD_SCAN_DONE = 1'b1
	} ssld_cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} ssld_state_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic ins;    // insert the new key at its sorted place
		logic shift;  // move every entry one cell toward the head
	} ssld_ctl_t;

endpackage

[rtl/ssld_cell.sv]
module ssld_cell #(
	parameter int CNT_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  logic                                clk,
	input  ssld_pkg::ssld_ctl_t                 ctl,
	input  logic [CNT_W-1:0]                    count,
	input  logic [ssld_pkg::SSLD_WORD_W-1:0]    key,
	input  logic [ssld_pkg::SSLD_WORD_W-1:0]    prev_word,
	input  logic                                prev_after,
	input  logic [ssld_pkg::SSLD_WORD_W-1:0]    next_word,
	output logic [ssld_pkg::SSLD_WORD_W-1:0]    word,
	output logic                                after,
	output logic                                match
);
	import ssld_pkg::*;

	logic [SSLD_WORD_W-1:0] word_q;
	logic                   occ;

	// Occupancy follows from the fill count
	assign occ   = CNT_W'(CELL_IDX) < count;
	assign match = occ && (word_q[SSLD_ADDR_W-1:0] == key[SSLD_ADDR_W-1:0]);
	// At or past the insert point: empty, or holding a strictly larger key
	assign after = !occ || (word_q > key);
	assign word  = word_q;

	// Shift toward the head on readout; on insert take the key or the neighbor's entry
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			word_q <= next_word;
		end else if (ctl.ins && after) begin
			word_q <= prev_after ? prev_word : key;
		end
	end

endmodule

[rtl/sorted_scan_list_dedup_core.sv]
// Sorted scan list core. Adverts are taken one per cycle while not busy: every
// cell of the list compares its entry with the new key and shifts in the same
// cycle, so busy stays low through any run of adverts. A scan-complete beat
// reads the list out through the head cell, one result per cycle for the n
// entries held, or a single empty-marked result in the next cycle when the
// list is empty. Results appear on result_valid for exactly one cycle and
// cannot be held off; the receiver must take them as they come. No clearing
// pass is needed after reset.
module sorted_scan_list_dedup_core #(
	parameter int LIST_DEPTH = ssld_pkg::SSLD_LIST_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cmd,
	input  logic [ssld_pkg::SSLD_ADDR_W-1:0]      device_address,
	input  logic signed [ssld_pkg::SSLD_RSSI_W-1:0] signal_strength,
	input  logic [ssld_pkg::SSLD_PREFIX_W-1:0]    adv_prefix,
	input  logic                                  adv_well_formed,
	// results
	output logic                                  result_valid,
	output logic [ssld_pkg::SSLD_WORD_W-1:0]      entry_word,
	output logic [ssld_pkg::SSLD_INDEX_W-1:0]     entry_index,
	output logic [ssld_pkg::SSLD_TOTAL_W-1:0]     total_entries,
	output logic                                  list_empty,
	output logic                                  last_in_run,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ssld_pkg::SSLD_CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssld_pkg::SSLD_PREFIX_W-1:0]    cfg_data
);
	import ssld_pkg::*;

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	ssld_state_t state_q, state_d;

	logic [SSLD_PREFIX_W-1:0] reject_pattern_q;
	logic                     reject_enable_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         total_q;
	logic [CNT_W-1:0]         rd_idx_q;

	logic                     res_valid_q;
	logic [SSLD_WORD_W-1:0]   res_word_q;
	logic [CNT_W-1:0]         res_idx_q;
	logic [CNT_W-1:0]         res_total_q;
	logic                     res_empty_q;
	logic                     res_last_q;

	logic                     accept;
	logic                     advert_ok;
	logic                     dup;
	logic                     ins_go;
	logic                     rd_last;
	logic [7:0]               rssi_bits;
	logic [7:0]               rssi_mag;
	logic [SSLD_WORD_W-1:0]   key;
	logic [63:0]              idx_ext;
	logic [63:0]              total_ext;
	ssld_ctl_t                ctl;

	logic [SSLD_WORD_W-1:0]   cell_word  [LIST_DEPTH];
	logic [SSLD_WORD_W-1:0]   cell_prev  [LIST_DEPTH];
	logic [SSLD_WORD_W-1:0]   cell_next  [LIST_DEPTH];
	logic [LIST_DEPTH-1:0]    cell_after;
	logic [LIST_DEPTH-1:0]    cell_prev_after;
	logic [LIST_DEPTH-1:0]    cell_match;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q == ST_READ);
	assign accept    = start && !busy;

	// Pack the key: rssi magnitude, reserved byte, address
	assign rssi_bits = signal_strength;
	assign rssi_mag  = rssi_bits[7] ? 8'(8'd0 - rssi_bits) : rssi_bits;
	assign key       = {rssi_mag, SSLD_RESERVED, device_address};

	// Filter malformed and rejected beacons, then drop known addresses
	assign advert_ok = adv_well_formed &&
	                   !(reject_enable_q && (adv_prefix == reject_pattern_q));
	assign dup       = |cell_match;
	assign ins_go    = accept && (cmd == CMD_ADVERT) && advert_ok && !dup;
	assign rd_last   = (rd_idx_q == CNT_W'(total_q - 1'b1));

	assign ctl.ins   = ins_go;
	assign ctl.shift = busy;

	// Chain the cells: each sees its neighbors' entries and insert flags
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_prev[i]       = key;
			assign cell_prev_after[i] = 1'b0;
		end else begin : g_body
			assign cell_prev[i]       = cell_word[i-1];
			assign cell_prev_after[i] = cell_after[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_tail
			assign cell_next[i] = cell_word[i];
		end else begin : g_mid
			assign cell_next[i] = cell_word[i+1];
		end

		ssld_cell #(
			.CNT_W   (CNT_W),
			.CELL_IDX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.key       (key),
			.prev_word (cell_prev[i]),
			.prev_after(cell_prev_after[i]),
			.next_word (cell_next[i]),
			.word      (cell_word[i]),
			.after     (cell_after[i]),
			.match     (cell_match[i])
		);
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_pattern_q <= SSLD_REJECT_RESET;
			reject_enable_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REJECT_PATTERN: reject_pattern_q <= cfg_data;
				REG_REJECT_ENABLE:  reject_enable_q  <= cfg_data[0];
				default:            reject_pattern_q <= reject_pattern_q;
			endcase
		end
	end

	// Next state of the readout sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_SCAN_DONE) && (count_q != '0)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track the fill count and the readout position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			total_q  <= '0;
			rd_idx_q <= '0;
		end else if (accept && (cmd == CMD_SCAN_DONE)) begin
			total_q  <= count_q;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (ins_go && (count_q != DEPTH_C)) begin
				count_q <= count_q + 1'b1;
			end
			if (busy) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= busy || (accept && (cmd == CMD_SCAN_DONE) && (count_q == '0));
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			res_word_q  <= cell_word[0];
			res_idx_q   <= rd_idx_q;
			res_total_q <= total_q;
			res_empty_q <= 1'b0;
			res_last_q  <= rd_last;
		end else begin
			res_word_q  <= '0;
			res_idx_q   <= '0;
			res_total_q <= '0;
			res_empty_q <= 1'b1;
			res_last_q  <= 1'b1;
		end
	end

	// Mask index and total to the port widths
	assign idx_ext   = 64'(res_idx_q);
	assign total_ext = 64'(res_total_q);

	assign result_valid  = res_valid_q;
	assign entry_word    = res_word_q;
	assign entry_index   = idx_ext[SSLD_INDEX_W-1:0];
	assign total_entries = total_ext[SSLD_TOTAL_W-1:0];
	assign list_empty    = res_empty_q;
	assign last_in_run   = res_last_q;

`include "sorted_scan_list_dedup_core_assert.svh"

	`SSLD_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C, "fill count past depth")
	`SSLD_ASSERT_SAME(a_last_idle, clk, arst_n, result_valid && last_in_run, !busy, "busy after final result")
	`SSLD_ASSERT_SAME(a_mid_busy, clk, arst_n, result_valid && !last_in_run, busy, "readout ended early")
	`SSLD_ASSERT_NEXT(a_read_beat, clk, arst_n, busy, result_valid, "readout cycle without result")
	`SSLD_ASSERT_NEXT(a_scan_clear, clk, arst_n, accept && (cmd == CMD_SCAN_DONE), count_q == '0, "list not cleared on scan complete")

endmodule

[bench/tb_sorted_scan_list_dedup_core.sv]
`timescale 1ns / 100ps

module tb_sorted_scan_list_dedup_core;
	import ssld_pkg::*;

	// One command beat as driven on the input ports
	typedef struct {
		ssld_cmd_t                 cmd;
		logic [SSLD_ADDR_W-1:0]    addr;
		logic [SSLD_RSSI_W-1:0]    rssi;
		logic [SSLD_PREFIX_W-1:0]  prefix;
		logic                      well_formed;
	} scan_beat_t;

	// One readout beat as seen on the result ports
	typedef struct packed {
		logic [SSLD_WORD_W-1:0]    word;
		logic [SSLD_INDEX_W-1:0]   index;
		logic [SSLD_TOTAL_W-1:0]   total;
		logic                      empty;
		logic                      last;
	} readout_t;

	// Directed step: the beat and, where obvious, its single readout beat
	typedef struct {
		scan_beat_t beat;
		bit         typed;
		readout_t   res;
	} script_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic                        cmd = 1'b0;
	logic [SSLD_ADDR_W-1:0]      device_address = '0;
	logic signed [SSLD_RSSI_W-1:0] signal_strength = '0;
	logic [SSLD_PREFIX_W-1:0]    adv_prefix = '0;
	logic                        adv_well_formed = 1'b0;
	logic                        result_valid;
	logic [SSLD_WORD_W-1:0]      entry_word;
	logic [SSLD_INDEX_W-1:0]     entry_index;
	logic [SSLD_TOTAL_W-1:0]     total_entries;
	logic                        list_empty;
	logic                        last_in_run;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [SSLD_CFG_IDX_W-1:0]   cfg_index = '0;
	logic [SSLD_PREFIX_W-1:0]    cfg_data = '0;

	// Shadow copy of the list and the registers
	logic [SSLD_WORD_W-1:0]      held_keys [SSLD_LIST_DEPTH];
	int                          held_count = 0;
	logic [SSLD_PREFIX_W-1:0]    shadow_pattern = SSLD_REJECT_RESET;
	logic                        shadow_enable = 1'b1;

	readout_t                    expected_readout [$];
	script_row_t                 script [$];
	logic [SSLD_ADDR_W-1:0]      addr_pool [8];

	bit  start_high = 1'b0;
	int  burst_left = 1;
	int  mismatch_count = 0;
	int  results_checked = 0;
	int  adverts_sent = 0;
	int  scans_sent = 0;
	int  cfg_writes = 0;
	int  lists_filled = 0;
	int  list_changes = 0;

	sorted_scan_list_dedup_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.device_address  (device_address),
		.signal_strength (signal_strength),
		.adv_prefix      (adv_prefix),
		.adv_well_formed (adv_well_formed),
		.result_valid    (result_valid),
		.entry_word      (entry_word),
		.entry_index     (entry_index),
		.total_entries   (total_entries),
		.list_empty      (list_empty),
		.last_in_run     (last_in_run),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// Key: {|rssi|, reserved byte, address}; smaller means stronger
	function automatic logic [SSLD_WORD_W-1:0] pack_sighting(logic [SSLD_ADDR_W-1:0] addr,
			logic [SSLD_RSSI_W-1:0] rssi);
		logic [SSLD_RSSI_W-1:0] magnitude;
		magnitude = rssi[SSLD_RSSI_W-1] ? SSLD_RSSI_W'(~rssi + 1'b1) : rssi;
		return {magnitude, SSLD_RESERVED, addr};
	endfunction

	// Advance the shadow list by one accepted beat; queue the readout it causes
	task automatic update_scan_list(input scan_beat_t b, input bit keep, output bit acted);
		logic [SSLD_WORD_W-1:0] key;
		int pos;
		int n;
		acted = 1'b0;
		if (b.cmd == CMD_ADVERT) begin
			if (!b.well_formed)
				return;
			if (shadow_enable && b.prefix == shadow_pattern)
				return;
			key = pack_sighting(b.addr, b.rssi);
			for (int i = 0; i < held_count; i++)
				if (held_keys[i][SSLD_ADDR_W-1:0] == b.addr)
					return;
			pos = 0;
			while (pos < held_count && held_keys[pos] <= key)
				pos++;
			if (pos >= SSLD_LIST_DEPTH)
				return;
			for (int j = (held_count < SSLD_LIST_DEPTH) ? held_count : SSLD_LIST_DEPTH - 1;
					j > pos; j--)
				held_keys[j] = held_keys[j-1];
			held_keys[pos] = key;
			if (held_count < SSLD_LIST_DEPTH)
				held_count++;
			else
				lists_filled++;
			acted = 1'b1;
		end else begin
			acted = 1'b1;
			n = held_count;
			held_count = 0;
			if (!keep)
				return;
			if (n == 0)
				expected_readout.push_back('{word: '0, index: '0, total: '0, empty: 1'b1,
					last: 1'b1});
			for (int k = 0; k < n; k++)
				expected_readout.push_back('{word: held_keys[k], index: SSLD_INDEX_W'(k),
					total: SSLD_TOTAL_W'(n), empty: 1'b0, last: (k == n - 1)});
		end
	endtask

	// Drive one beat, hold it until taken, then pace the sender in bursts
	task automatic issue_beat(input scan_beat_t b, input bit typed, input readout_t res,
			output bit acted);
		int gap;
		start <= 1'b1;
		start_high = 1'b1;
		cmd <= b.cmd;
		device_address <= b.addr;
		signal_strength <= b.rssi;
		adv_prefix <= b.prefix;
		adv_well_formed <= b.well_formed;
		do @(posedge clk); while (busy);
		update_scan_list(b, !typed, acted);
		if (typed)
			expected_readout.push_back(res);
		if (b.cmd == CMD_ADVERT)
			adverts_sent++;
		else
			scans_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
			start <= 1'b0;
			start_high = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write one register and mirror it; valid stays up for a following write
	task automatic write_reg(input ssld_reg_t idx, input logic [SSLD_PREFIX_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_REJECT_PATTERN)
			shadow_pattern = value;
		else
			shadow_enable = value[0];
		cfg_writes++;
	endtask

	// Drop start, wait out the readout, then idle to let a trailing advert land
	task automatic settle();
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (expected_readout.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_row(input ssld_cmd_t c, input logic [SSLD_ADDR_W-1:0] a,
			input logic [SSLD_RSSI_W-1:0] r, input logic [SSLD_PREFIX_W-1:0] p,
			input logic w, input bit typed, input logic [SSLD_WORD_W-1:0] word,
			input logic [SSLD_TOTAL_W-1:0] total);
		script_row_t row;
		row.beat = '{cmd: c, addr: a, rssi: r, prefix: p, well_formed: w};
		row.typed = typed;
		row.res = '{word: word, index: '0, total: total, empty: (total == 0), last: 1'b1};
		script.push_back(row);
	endtask

	// Mostly well-formed adverts from a small address pool, with scans sprinkled in
	function automatic scan_beat_t draw_beat(int scan_odds);
		scan_beat_t b;
		int pick;
		b.cmd = ($urandom_range(1, scan_odds) == 1) ? CMD_SCAN_DONE : CMD_ADVERT;
		b.addr = ($urandom_range(0, 1) == 0) ? addr_pool[$urandom_range(0, 7)]
			: {16'($urandom), $urandom};
		pick = $urandom_range(0, 15);
		b.rssi = (pick == 0) ? 8'h80 : (pick == 1) ? 8'h7f : 8'($urandom);
		pick = $urandom_range(0, 9);
		b.prefix = (pick == 0) ? shadow_pattern
			: (pick == 1) ? shadow_pattern ^ (40'd1 << $urandom_range(0, 39))
			: {8'($urandom), $urandom};
		b.well_formed = ($urandom_range(0, 9) != 0);
		return b;
	endfunction

	// Check each readout beat against the oldest expectation
	always @(posedge clk) begin
		readout_t seen;
		readout_t want;
		if (arst_n && result_valid) begin
			seen = {entry_word, entry_index, total_entries, list_empty, last_in_run};
			if (expected_readout.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected readout beat: word %h idx %0d total %0d empty %b last %b",
						seen.word, seen.index, seen.total, seen.empty, seen.last);
			end else begin
				want = expected_readout.pop_front();
				results_checked++;
				if (seen.word !== want.word || seen.index !== want.index ||
						seen.total !== want.total || seen.empty !== want.empty ||
						seen.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("readout mismatch at %0t", $realtime);
						$display("  want word %h idx %0d total %0d empty %b last %b",
							want.word, want.index, want.total, want.empty, want.last);
						$display("  got  word %h idx %0d total %0d empty %b last %b",
							seen.word, seen.index, seen.total, seen.empty, seen.last);
					end
				end
			end
		end
	end

	initial begin
		bit acted;
		int taken;
		int scan_odds;
		logic [SSLD_PREFIX_W-1:0] pat;
		logic en;
		scan_beat_t flush;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty readout, magnitude extremes, drops, ordering, duplicates
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b1, 1, '0, 5'd0);
		add_row(CMD_ADVERT, '0, 8'h80, '0, 1'b1, 0, '0, '0);
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b0, 1, 64'h80ff_0000_0000_0000, 5'd1);
		add_row(CMD_ADVERT, '1, 8'h7f, '1, 1'b1, 0, '0, '0);
		add_row(CMD_SCAN_DONE, '1, '1, '1, 1'b1, 1, 64'h7fff_ffff_ffff_ffff, 5'd1);
		add_row(CMD_ADVERT, 48'd1, 8'h00, '0, 1'b0, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd2, 8'hff, SSLD_REJECT_RESET, 1'b1, 0, '0, '0);
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b1, 1, '0, 5'd0);
		add_row(CMD_ADVERT, 48'd3, -8'sd5, 40'h12_3456_789a, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd3, -8'sd1, 40'h12_3456_789a, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd4, -8'sd5, '0, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd5, 8'sd5, '0, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd6, -8'sd1, SSLD_REJECT_RESET ^ 40'd1, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd7, 8'sd0, '0, 1'b1, 0, '0, '0);
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b1, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd8, -8'sd40, SSLD_REJECT_RESET, 1'b0, 0, '0, '0);
		add_row(CMD_ADVERT, 48'd9, -8'sd40, '0, 1'b1, 0, '0, '0);
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b1, 1, 64'h28ff_0000_0000_0009, 5'd1);
		add_row(CMD_SCAN_DONE, '0, '0, '0, 1'b1, 1, '0, 5'd0);
		foreach (script[i])
			issue_beat(script[i].beat, script[i].typed, script[i].res, acted);
		settle();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin pat = '0;                      en = 1'b1; scan_odds = 8;  end
				1: begin pat = '1;                      en = 1'b1; scan_odds = 40; end
				2: begin pat = {8'($urandom), $urandom}; en = 1'b0; scan_odds = 12; end
				3: begin pat = SSLD_REJECT_RESET;       en = 1'b0; scan_odds = 20; end
				default: begin
					pat = {8'($urandom), $urandom};
					en = 1'b1;
					scan_odds = 5;
				end
			endcase
			write_reg(REG_REJECT_PATTERN, pat);
			write_reg(REG_REJECT_ENABLE, {39'($urandom), en});
			cfg_valid <= 1'b0;
			foreach (addr_pool[i])
				addr_pool[i] = {16'($urandom), $urandom};
			taken = 0;
			while (taken < 56) begin
				issue_beat(draw_beat(scan_odds), 0, '0, acted);
				taken++;
				if (acted)
					list_changes++;
			end
			// Flush what the phase left in the list
			flush = draw_beat(scan_odds);
			flush.cmd = CMD_SCAN_DONE;
			issue_beat(flush, 0, '0, acted);
			settle();
		end

		repeat (16) @(posedge clk);
		$display("Covered %0d adverts, %0d scan completions, %0d random list changes, %0d full-list inserts",
			adverts_sent, scans_sent, list_changes, lists_filled);
		$display("Checked %0d readout beats over %0d register writes, %0d mismatches",
			results_checked, cfg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ssld_pkg.sv
rtl/ssld_cell.sv
rtl/sorted_scan_list_dedup_core.sv
bench/tb_sorted_scan_list_dedup_core.sv
